// File: sv/rrtr_pkg.sv
// ----------------------------------------------------------------------------
// rrtr_pkg
// Shared types and codes for the round-robin turn ring: operation and status
// codes, the request and result words, and one stored ring entry.
// ----------------------------------------------------------------------------
package rrtr_pkg;

  localparam int unsigned MAX_PLAYERS_DEF = 16;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned SCORE_W = 32;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_NEXT   = 3'd2,
    OP_SKIP   = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_REMOVED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_REPORTED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]                operation;
    logic [ID_W-1:0]           entry_id;
    logic signed [SCORE_W-1:0] entry_score;
  } req_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [ID_W-1:0]           out_id;
    logic signed [SCORE_W-1:0] out_score;
    logic [ID_W-1:0]           skipped_id;
    logic                      single_left;
    logic                      last_of_run;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

endpackage

// File: sv/rrtr_store.sv
// ----------------------------------------------------------------------------
// rrtr_store
// Entry memory of the ring: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module rrtr_store import rrtr_pkg::*; #(
  parameter int unsigned Depth = MAX_PLAYERS_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/round_robin_turn_ring.sv
// ----------------------------------------------------------------------------
// round_robin_turn_ring
// Ordered ring of entries (id, score) with a turn pointer: add, remove,
// next turn, skip and list, run by a small sequencer over one entry memory.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low; each result word
// shows on res_o for exactly one cycle with res_valid_o high and cannot be
// held off. Add, a refused add, any operation on an empty ring and unused
// operation codes keep busy_o low, the result (if any) is registered and a
// new word can be taken in the very next cycle. Next turn passes through
// S_REPORT, skip through S_PEEK and then S_REPORT. List stays busy in S_LIST
// and emits one entry per cycle. Remove steps through the slots in S_SCAN
// until it finds the entry and then closes the gap in S_SHIFT; a remove that
// finds nothing scans every slot. This sequencing comes from the single read
// port of the entry memory, which is visited one slot per cycle, and from the
// one shared increment-and-compare unit that steps the scan and wraps the
// turn pointer.
module round_robin_turn_ring import rrtr_pkg::*; #(
  parameter int unsigned MaxPlayers = MAX_PLAYERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IdxW = $clog2(MaxPlayers);
  localparam int unsigned CntW = $clog2(MaxPlayers + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPlayers);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PEEK   = 6'b000010,
    S_REPORT = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_LIST   = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] turn_q, turn_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] wr_q, wr_d;
  logic [IdxW-1:0] found_q, found_d;
  logic [ID_W-1:0] key_q, key_d;
  logic [ID_W-1:0] skip_q, skip_d;
  entry_t          rem_q, rem_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  // memory port
  logic            mem_we;
  logic [IdxW-1:0] mem_wr_addr;
  entry_t          mem_wr_data;
  logic [IdxW-1:0] mem_rd_addr;
  entry_t          mem_rd_data;

  // shared increment-and-compare unit
  logic [CntW-1:0] unit_in;
  logic [CntW-1:0] unit_inc;
  logic            unit_end;
  logic [IdxW-1:0] wrap_pos;

  // remove epilogue
  logic [CntW-1:0] cnt_m1;
  logic [IdxW-1:0] turn_dec;
  logic            shift_done;

  rrtr_store #(
    .Depth(MaxPlayers)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  always_comb begin
    if (state_q == S_IDLE || state_q == S_PEEK) begin
      unit_in = CntW'(turn_q);
    end else begin
      unit_in = idx_q;
    end
  end

  assign unit_inc = unit_in + CntOne;
  assign unit_end = (unit_inc >= count_q);
  assign wrap_pos = unit_end ? '0 : unit_inc[IdxW-1:0];

  assign cnt_m1     = count_q - CntOne;
  assign turn_dec   = (turn_q > found_q) ? (turn_q - IdxW'(1)) : turn_q;
  assign shift_done = (idx_q >= count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    turn_d      = turn_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    found_d     = found_q;
    key_d       = key_q;
    skip_d      = skip_q;
    rem_d       = rem_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_wr_addr = count_q[IdxW-1:0];
    mem_wr_data = '{id: req_i.entry_id, score: req_i.entry_score};
    mem_rd_addr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.operation)
            OP_ADD: begin
              res_valid_d       = 1'b1;
              res_d             = '0;
              res_d.out_id      = req_i.entry_id;
              res_d.out_score   = req_i.entry_score;
              res_d.last_of_run = 1'b1;
              if (count_q >= CntMax) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we            = 1'b1;
                count_d           = count_q + CntOne;
                res_d.status      = STAT_ADDED;
                res_d.single_left = (count_q == '0);
              end
            end
            OP_REMOVE, OP_NEXT, OP_SKIP, OP_LIST: begin
              if (count_q == '0) begin
                turn_d            = '0;
                res_valid_d       = 1'b1;
                res_d             = '0;
                res_d.status      = STAT_EMPTY;
                res_d.last_of_run = 1'b1;
              end else begin
                unique case (req_i.operation)
                  OP_REMOVE: begin
                    idx_d   = '0;
                    key_d   = req_i.entry_id;
                    state_d = S_SCAN;
                  end
                  OP_NEXT: begin
                    mem_rd_addr = turn_q;
                    turn_d      = wrap_pos;
                    skip_d      = '0;
                    state_d     = S_REPORT;
                  end
                  OP_SKIP: begin
                    mem_rd_addr = turn_q;
                    turn_d      = wrap_pos;
                    state_d     = S_PEEK;
                  end
                  default: begin
                    idx_d   = '0;
                    state_d = S_LIST;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
      end

      // skipped entry arrives, fetch the one after it
      S_PEEK: begin
        skip_d      = mem_rd_data.id;
        mem_rd_addr = turn_q;
        turn_d      = wrap_pos;
        state_d     = S_REPORT;
      end

      S_REPORT: begin
        res_valid_d       = 1'b1;
        res_d             = '0;
        res_d.status      = STAT_REPORTED;
        res_d.out_id      = mem_rd_data.id;
        res_d.out_score   = mem_rd_data.score;
        res_d.skipped_id  = skip_q;
        res_d.single_left = (count_q == CntOne);
        res_d.last_of_run = 1'b1;
        state_d           = S_IDLE;
      end

      S_SCAN: begin
        if (mem_rd_data.id == key_q) begin
          rem_d       = mem_rd_data;
          found_d     = idx_q[IdxW-1:0];
          wr_d        = idx_q[IdxW-1:0];
          idx_d       = unit_inc;
          mem_rd_addr = unit_inc[IdxW-1:0];
          state_d     = S_SHIFT;
        end else if (unit_end) begin
          res_valid_d       = 1'b1;
          res_d             = '0;
          res_d.status      = STAT_NOT_FOUND;
          res_d.out_id      = key_q;
          res_d.single_left = (count_q == CntOne);
          res_d.last_of_run = 1'b1;
          state_d           = S_IDLE;
        end else begin
          idx_d       = unit_inc;
          mem_rd_addr = unit_inc[IdxW-1:0];
        end
      end

      // move the later entries down by one, one per cycle
      S_SHIFT: begin
        if (shift_done) begin
          count_d = cnt_m1;
          if (CntW'(turn_dec) >= cnt_m1) begin
            turn_d = '0;
          end else begin
            turn_d = turn_dec;
          end
          res_valid_d       = 1'b1;
          res_d             = '0;
          res_d.status      = STAT_REMOVED;
          res_d.out_id      = rem_q.id;
          res_d.out_score   = rem_q.score;
          res_d.single_left = (cnt_m1 == CntOne);
          res_d.last_of_run = 1'b1;
          state_d           = S_IDLE;
        end else begin
          mem_we      = 1'b1;
          mem_wr_addr = wr_q;
          mem_wr_data = mem_rd_data;
          wr_d        = idx_q[IdxW-1:0];
          idx_d       = unit_inc;
          mem_rd_addr = unit_inc[IdxW-1:0];
        end
      end

      S_LIST: begin
        res_valid_d       = 1'b1;
        res_d             = '0;
        res_d.status      = STAT_REPORTED;
        res_d.out_id      = mem_rd_data.id;
        res_d.out_score   = mem_rd_data.score;
        res_d.single_left = (count_q == CntOne);
        res_d.last_of_run = unit_end;
        if (unit_end) begin
          state_d = S_IDLE;
        end else begin
          idx_d       = unit_inc;
          mem_rd_addr = unit_inc[IdxW-1:0];
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      turn_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      turn_q      <= turn_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    wr_q    <= wr_d;
    found_q <= found_d;
    key_q   <= key_d;
    skip_q  <= skip_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/rrtr_checker.sv
// ----------------------------------------------------------------------------
// rrtr_checker
// Port-level checks of the turn ring: how results line up with busy and
// with the words that caused them.
// ----------------------------------------------------------------------------
module rrtr_checker import rrtr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic res_valid_o,
  input res_t res_o
);

  logic take;
  assign take = start_i && !busy_o;

  // the run ends exactly when the block goes idle
  a_last_vs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (busy_o == !res_o.last_of_run))
    else $error("last_of_run does not match busy");

  // only reported entries can belong to a multi-word run
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != STAT_REPORTED) |->
      (res_o.last_of_run && res_o.skipped_id == '0))
    else $error("status word is not a single closing word");

  // add answers in the next cycle with added or full
  a_add_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && req_i.operation == OP_ADD) |=>
      (res_valid_o && !busy_o &&
       (res_o.status == STAT_ADDED || res_o.status == STAT_FULL)))
    else $error("add did not answer in the next cycle");

  // unused operation codes leave no trace
  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && req_i.operation != OP_ADD && req_i.operation != OP_REMOVE &&
     req_i.operation != OP_NEXT && req_i.operation != OP_SKIP &&
     req_i.operation != OP_LIST) |=> (!res_valid_o && !busy_o))
    else $error("unused operation produced activity");

endmodule

bind round_robin_turn_ring rrtr_checker u_rrtr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .req_i      (req_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin turn ring. A fixed list of words
// covers the empty, single-entry, full and not-found cases first. Random
// add-heavy and remove-heavy runs with and without sender gaps follow. Each
// result word is checked field by field against a local ring model or a set word.
// ----------------------------------------------------------------------------
module tb_top import rrtr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]           OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]           OP_UNUSED_HI = 3'd7;
  localparam logic signed [31:0]   SCORE_MAX    = 32'sh7fff_ffff;
  localparam logic signed [31:0]   SCORE_MIN    = 32'sh8000_0000;
  localparam int unsigned          DRAIN_CYCLES = 40;

  typedef struct {
    req_t        w;
    int unsigned reps;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  // model of the ring
  entry_t      ring_slot [MAX_PLAYERS_DEF];
  int unsigned ring_len = 0;
  int unsigned turn_pos = 0;
  res_t        ring_out [$];

  res_t        awaited_words [$];
  res_t        head_word;
  dir_row_t    dir_rows [$];

  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned full_seen     = 0;
  int unsigned empty_seen    = 0;
  int unsigned add_pct [3]   = '{50, 12, 30};
  int unsigned rem_pct [3]   = '{8, 45, 25};
  int unsigned phase_idle [4] = '{0, 62, 0, 34};

  round_robin_turn_ring u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned next_slot(int unsigned p);
    if (ring_len == 0) return 0;
    return (p + 1 >= ring_len) ? 0 : p + 1;
  endfunction

  // works out the result words of one accepted word into ring_out
  function automatic void step_ring(req_t w);
    int unsigned i, hit, cur, nxt;
    res_t r;
    ring_out.delete();
    r = '0;
    r.last_of_run = 1'b1;
    if (w.operation > OP_LIST) return;
    if (w.operation == OP_ADD) begin
      r.out_id    = w.entry_id;
      r.out_score = w.entry_score;
      if (ring_len >= MAX_PLAYERS_DEF) begin
        r.status = STAT_FULL;
      end else begin
        ring_slot[ring_len].id    = w.entry_id;
        ring_slot[ring_len].score = w.entry_score;
        if (ring_len == 0) turn_pos = 0;
        ring_len++;
        r.status = STAT_ADDED;
      end
      r.single_left = (ring_len == 1);
      ring_out.push_back(r);
      return;
    end
    if (ring_len == 0) begin
      turn_pos = 0;
      r.status = STAT_EMPTY;
      ring_out.push_back(r);
      return;
    end
    if (turn_pos >= ring_len) turn_pos = 0;
    case (w.operation)
      OP_REMOVE: begin
        hit = ring_len;
        for (i = 0; i < ring_len; i++)
          if (hit == ring_len && ring_slot[i].id == w.entry_id) hit = i;
        if (hit == ring_len) begin
          r.status = STAT_NOT_FOUND;
          r.out_id = w.entry_id;
        end else begin
          r.status    = STAT_REMOVED;
          r.out_id    = ring_slot[hit].id;
          r.out_score = ring_slot[hit].score;
          for (i = hit; i + 1 < ring_len; i++) ring_slot[i] = ring_slot[i + 1];
          ring_len--;
          if (turn_pos > hit) turn_pos--;
          if (turn_pos >= ring_len) turn_pos = 0;
        end
        r.single_left = (ring_len == 1);
        ring_out.push_back(r);
      end
      OP_NEXT: begin
        cur         = turn_pos;
        turn_pos    = next_slot(cur);
        r.status    = STAT_REPORTED;
        r.out_id    = ring_slot[cur].id;
        r.out_score = ring_slot[cur].score;
        r.single_left = (ring_len == 1);
        ring_out.push_back(r);
      end
      OP_SKIP: begin
        cur          = turn_pos;
        nxt          = next_slot(cur);
        turn_pos     = next_slot(nxt);
        r.status     = STAT_REPORTED;
        r.out_id     = ring_slot[nxt].id;
        r.out_score  = ring_slot[nxt].score;
        r.skipped_id = ring_slot[cur].id;
        r.single_left = (ring_len == 1);
        ring_out.push_back(r);
      end
      default: begin
        for (i = 0; i < ring_len; i++) begin
          r.status      = STAT_REPORTED;
          r.out_id      = ring_slot[i].id;
          r.out_score   = ring_slot[i].score;
          r.single_left = (ring_len == 1);
          r.last_of_run = (i + 1 == ring_len);
          ring_out.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_word(res_t got, res_t want);
    if (got.status !== want.status)
      report_mismatch("status", 128'(got.status), 128'(want.status));
    if (got.out_id !== want.out_id)
      report_mismatch("out_id", 128'(got.out_id), 128'(want.out_id));
    if (got.out_score !== want.out_score)
      report_mismatch("out_score", 128'(got.out_score), 128'(want.out_score));
    if (got.skipped_id !== want.skipped_id)
      report_mismatch("skipped_id", 128'(got.skipped_id), 128'(want.skipped_id));
    if (got.single_left !== want.single_left)
      report_mismatch("single_left", 128'(got.single_left), 128'(want.single_left));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", 128'(got.last_of_run), 128'(want.last_of_run));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("word with none awaited", 128'(res_o), '0);
      end else begin
        head_word = awaited_words.pop_front();
        check_word(res_o, head_word);
        words_checked++;
        if (head_word.status == STAT_FULL) full_seen++;
        if (head_word.status == STAT_EMPTY) empty_seen++;
      end
    end
  end

  function automatic res_t mk_res(status_e st, logic [15:0] id, logic signed [31:0] sc,
                                  logic [15:0] sk, logic one);
    res_t r;
    r             = '0;
    r.status      = st;
    r.out_id      = id;
    r.out_score   = sc;
    r.skipped_id  = sk;
    r.single_left = one;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [15:0] id, logic signed [31:0] sc,
                                  int unsigned reps, bit typed, res_t want);
    dir_row_t row;
    row.w.operation   = op;
    row.w.entry_id    = id;
    row.w.entry_score = sc;
    row.reps          = reps;
    row.typed         = typed;
    row.want          = want;
    dir_rows.push_back(row);
  endfunction

  function automatic req_t random_word(int unsigned mood);
    req_t w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    // mostly a small id pool so removes hit and duplicates occur
    w.entry_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
    case ($urandom_range(0, 9))
      0:       w.entry_score = SCORE_MAX;
      1:       w.entry_score = SCORE_MIN;
      default: w.entry_score = $urandom;
    endcase
    if (roll < add_pct[mood]) w.operation = OP_ADD;
    else if (roll < add_pct[mood] + rem_pct[mood]) w.operation = OP_REMOVE;
    else if (roll < 97) w.operation = 3'(OP_NEXT + $urandom_range(0, OP_LIST - OP_NEXT));
    else w.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(req_t w, int unsigned idle_pct, bit typed, res_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    step_ring(w);
    if (typed) awaited_words.push_back(want);
    else foreach (ring_out[k]) awaited_words.push_back(ring_out[k]);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    start_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned spin, phase, iter, counted, mood;
    req_t w;

    add_row(OP_REMOVE, 16'h0005, 0, 1, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0));
    add_row(OP_NEXT, 0, 0, 1, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0));
    add_row(OP_SKIP, 0, 0, 1, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0));
    add_row(OP_LIST, 0, 0, 1, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0));
    add_row(OP_UNUSED_LO, 16'hffff, -1, 1, 0, '0);
    add_row(OP_ADD, 16'hffff, SCORE_MIN, 1, 1, mk_res(STAT_ADDED, 16'hffff, SCORE_MIN, 0, 1));
    // single entry: skipped and reported at once
    add_row(OP_SKIP, 0, 0, 1, 1, mk_res(STAT_REPORTED, 16'hffff, SCORE_MIN, 16'hffff, 1));
    add_row(OP_NEXT, 0, 0, 1, 1, mk_res(STAT_REPORTED, 16'hffff, SCORE_MIN, 0, 1));
    add_row(OP_ADD, 16'h0000, SCORE_MAX, 1, 1, mk_res(STAT_ADDED, 0, SCORE_MAX, 0, 0));
    add_row(OP_ADD, 16'hffff, 0, 1, 0, '0);
    add_row(OP_LIST, 0, 0, 1, 0, '0);
    add_row(OP_REMOVE, 16'hffff, 0, 1, 0, '0);
    add_row(OP_REMOVE, 16'h1234, 0, 1, 1, mk_res(STAT_NOT_FOUND, 16'h1234, 0, 0, 0));
    add_row(OP_SKIP, 0, 0, 1, 0, '0);
    add_row(OP_REMOVE, 16'h0000, 0, 1, 0, '0);
    add_row(OP_REMOVE, 16'hffff, 0, 1, 0, '0);
    add_row(OP_ADD, 16'h0100, 32'sh5a5a_a5a5, MAX_PLAYERS_DEF, 0, '0);
    add_row(OP_ADD, 16'habcd, -1, 1, 1, mk_res(STAT_FULL, 16'habcd, -1, 0, 0));
    add_row(OP_LIST, 0, 0, 1, 0, '0);
    add_row(OP_NEXT, 0, 0, 1, 0, '0);
    add_row(OP_SKIP, 0, 0, 1, 0, '0);
    add_row(OP_REMOVE, 16'h0107, 0, 1, 0, '0);
    add_row(OP_REMOVE, 16'h010f, 0, 1, 0, '0);
    add_row(OP_UNUSED_HI, 16'h5555, 0, 1, 0, '0);
    add_row(OP_LIST, 0, 0, 1, 0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      for (spin = 0; spin < dir_rows[r].reps; spin++) begin
        w = dir_rows[r].w;
        w.entry_id = w.entry_id + 16'(spin);
        send_word(w, 0, dir_rows[r].typed, dir_rows[r].want);
      end
    end
    drain_all();

    for (phase = 0; phase < 4; phase++) begin
      iter    = 0;
      counted = 0;
      mood    = 0;
      while (counted < 100) begin
        // pick a fill, drain or mixed mood every 30 words so full and empty come up
        if (iter % 30 == 0) mood = $urandom_range(0, 2);
        w = random_word(mood);
        send_word(w, phase_idle[phase], 0, '0);
        if (w.operation <= OP_LIST) counted++;
        iter++;
      end
      drain_all();
    end

    for (spin = 0; spin < 5000 && awaited_words.size() != 0; spin++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_words.size() != 0)
      report_mismatch("words never seen", 128'(awaited_words.size()), '0);

    $display("summary: %0d words sent, %0d result words checked", words_sent, words_checked);
    $display("summary: ring full refused %0d times, empty ring hit %0d times",
             full_seen, empty_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
